// ----- design/ccpc_pkg.sv -----
// shared types and constants of the chained cycle permutation cipher
package ccpc_pkg;

  localparam int SymCount  = 94;
  localparam int SymW      = $clog2(SymCount);
  localparam int FirstCode = 33;

  localparam int          Shift3   = 33;
  localparam logic [31:0] Recip3   = 32'((64'd1 << Shift3) / 3);
  localparam int          SymShift = 31 + SymW;
  localparam logic [31:0] RecipSym = 32'((64'd1 << SymShift) / SymCount);

  localparam logic [SymW-1:0] LastJ = SymW'(SymCount - 2);
  localparam logic [SymW-1:0] LastK = SymW'(SymCount - 1);

  typedef enum logic [2:0] {
    DS_SUM, DS_MUL3, DS_MIX, DS_PROD, DS_ABS, DS_MUL, DS_MOD
  } dstep_e;

  typedef struct packed {
    logic   latch_in;
    logic   load_gen;
    logic   draw_en;
    dstep_e step;
    logic   take_start;
    logic   take_head;
    logic   take_k;
    logic   probe_step;
    logic   commit;
    logic   set_prev;
    logic   rd_idx;
    logic   rd_prev;
    logic   emit;
  } ccpc_cmd_t;

  typedef struct packed {
    logic probe_hit;
    logic last_link;
    logic out_busy;
  } ccpc_sts_t;

endpackage

// ----- design/ccpc_ctrl.sv -----
// controller: sequences cycle build and symbol coding
module ccpc_ctrl import ccpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      first_i,
  output logic      in_stall_o,
  input  ccpc_sts_t sts_i,
  output ccpc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DRAW, ST_PLACE, ST_PROBE, ST_RD_IDX, ST_RD_PREV, ST_OUT
  } state_e;

  typedef enum logic [1:0] {PH_START, PH_HEAD, PH_LINK} phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  dstep_e step_q, step_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    phase_d = phase_q;
    step_d  = step_q;
    cmd_o.step = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.latch_in = 1'b1;
          if (first_i) begin
            cmd_o.load_gen = 1'b1;
            phase_d = PH_START;
            step_d  = DS_SUM;
            state_d = ST_DRAW;
          end else begin
            state_d = ST_RD_IDX;
          end
        end
      end
      ST_DRAW: begin
        cmd_o.draw_en = 1'b1;
        if (step_q == DS_MOD) begin
          state_d = ST_PLACE;
        end else begin
          step_d = dstep_e'(step_q + 3'd1);
        end
      end
      ST_PLACE: begin
        step_d = DS_SUM;
        unique case (phase_q)
          PH_START: begin
            cmd_o.take_start = 1'b1;
            phase_d = PH_HEAD;
            state_d = ST_DRAW;
          end
          PH_HEAD: begin
            cmd_o.take_head = 1'b1;
            phase_d = PH_LINK;
            state_d = ST_DRAW;
          end
          default: begin
            cmd_o.take_k = 1'b1;
            state_d = ST_PROBE;
          end
        endcase
      end
      ST_PROBE: begin
        if (sts_i.probe_hit) begin
          cmd_o.probe_step = 1'b1;
        end else begin
          cmd_o.commit = 1'b1;
          if (sts_i.last_link) begin
            cmd_o.set_prev = 1'b1;
            state_d = ST_RD_IDX;
          end else begin
            step_d  = DS_SUM;
            state_d = ST_DRAW;
          end
        end
      end
      ST_RD_IDX: begin
        cmd_o.rd_idx = 1'b1;
        state_d = ST_RD_PREV;
      end
      ST_RD_PREV: begin
        cmd_o.rd_prev = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_START;
      step_q  <= DS_SUM;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      step_q  <= step_d;
    end
  end

endmodule

// ----- design/ccpc_dp.sv -----
// datapath: generator, cycle position memory, coding and output register
module ccpc_dp import ccpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ccpc_cmd_t   cmd_i,
  output ccpc_sts_t   sts_o,
  input  logic [31:0] type_seed_i,
  input  logic [31:0] soft_seed_i,
  input  logic [7:0]  symbol_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  cipher_symbol_o,
  output logic        bad_symbol_o
);

  logic [31:0]     gen_a_q, gen_b_q, abs_q;
  logic            neg_q;
  logic [63:0]     mul_q;
  logic [SymW-1:0] draw_q, start_q, prev_q, cur_q, k_q, j_q;
  logic [SymCount-1:0] used_q;
  logic [SymW-1:0] pos_mem [SymCount];
  logic [SymW-1:0] rd_q, pi_q, raddr;
  logic [7:0]      sym_q;
  logic            out_valid_q, bad_q;
  logic [7:0]      cipher_q;

  logic [31:0] sum, qe3, r3, q3, t3, five_t, na, nb, op_a, op_b, qn, rn, rn_fix;
  logic        bad;
  logic [SymW-1:0] idx;
  logic [SymW:0]   diff, gap;

  assign sum    = gen_a_q + (gen_b_q << 1);
  assign qe3    = 32'(mul_q >> Shift3);
  assign r3     = abs_q - (qe3 + (qe3 << 1));
  assign q3     = qe3 + ((r3 >= 32'd3) ? 32'd1 : 32'd0);
  assign t3     = neg_q ? -q3 : q3;
  assign five_t = t3 + (t3 << 2);
  assign na     = gen_a_q ^ (five_t - gen_b_q);
  assign nb     = (t3 << 1) - na;
  assign qn     = 32'(mul_q >> SymShift);
  assign rn     = abs_q - 32'(qn * SymCount);
  assign rn_fix = (rn >= 32'(SymCount)) ? rn - 32'(SymCount) : rn;

  always_comb begin
    case (cmd_i.step)
      DS_MUL3: begin
        op_a = abs_q;
        op_b = Recip3;
      end
      DS_PROD: begin
        op_a = gen_a_q;
        op_b = gen_b_q;
      end
      default: begin
        op_a = abs_q;
        op_b = RecipSym;
      end
    endcase
  end

  assign bad  = (sym_q < 8'(FirstCode)) || ({1'b0, sym_q} >= 9'(FirstCode + SymCount));
  assign idx  = bad ? '0 : SymW'(sym_q - 8'(FirstCode));
  assign raddr = cmd_i.rd_idx ? idx : prev_q;
  assign diff = {1'b0, pi_q} - {1'b0, rd_q} - (SymW+1)'(1);
  assign gap  = diff[SymW] ? diff + (SymW+1)'(SymCount) : diff;

  assign sts_o.probe_hit = used_q[k_q] || (k_q == cur_q);
  assign sts_o.last_link = (j_q == LastJ);
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  // generator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_a_q <= '0;
      gen_b_q <= '0;
    end else if (cmd_i.load_gen) begin
      gen_a_q <= type_seed_i;
      gen_b_q <= soft_seed_i;
    end else if (cmd_i.draw_en && cmd_i.step == DS_MIX) begin
      gen_a_q <= na;
      gen_b_q <= nb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_en) begin
      case (cmd_i.step)
        DS_SUM: begin
          neg_q <= sum[31];
          abs_q <= sum[31] ? -sum : sum;
        end
        DS_ABS:  abs_q  <= mul_q[31] ? -mul_q[31:0] : mul_q[31:0];
        DS_MOD:  draw_q <= rn_fix[SymW-1:0];
        DS_MIX:  ;
        default: mul_q  <= 64'(op_a) * 64'(op_b);
      endcase
    end
  end

  // cycle build
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      prev_q  <= '0;
      used_q  <= '0;
    end else begin
      if (cmd_i.take_start) start_q <= draw_q;
      if (cmd_i.take_head) used_q <= '0;
      else if (cmd_i.commit) used_q[cur_q] <= 1'b1;
      if (cmd_i.set_prev) prev_q <= start_q;
      else if (cmd_i.emit && !bad) prev_q <= idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) sym_q <= symbol_i;
    if (cmd_i.take_head) begin
      cur_q <= draw_q;
      j_q   <= '0;
    end
    if (cmd_i.take_k) k_q <= draw_q;
    else if (cmd_i.probe_step) k_q <= (k_q == LastK) ? '0 : k_q + SymW'(1);
    if (cmd_i.commit) begin
      cur_q <= k_q;
      j_q   <= j_q + SymW'(1);
    end
  end

  // position memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_head) pos_mem[draw_q] <= '0;
    else if (cmd_i.commit) pos_mem[k_q] <= j_q + SymW'(1);
    rd_q <= pos_mem[raddr];
    if (cmd_i.rd_prev) pi_q <= rd_q;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      bad_q    <= bad;
      cipher_q <= bad ? 8'd0 : 8'(gap) + 8'(FirstCode);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cipher_symbol_o = cipher_q;
  assign bad_symbol_o    = bad_q;

endmodule

// ----- design/chained_cycle_permutation_cipher.sv -----
// top level: seed registers, controller and datapath of the cycle cipher
//
// input channel: one plain character per beat (symbol_i, first_of_string_i),
// taken at a clock edge with in_valid_i high and in_stall_o low.
// output channel: one coded character per beat (cipher_symbol_o, bad_symbol_o)
// held in an output register until out_stall_i is low.
// seeds are written over the apb port (type_seed at 0, soft_seed at 4).
// a character without first_of_string goes from accept through rd_idx, rd_prev
// and out, and the next beat is taken once the controller is back in idle:
// two reads on the single read port of the position memory and one subtract.
// first_of_string rebuilds the cycle first: each generator draw steps through
// sum, mul3, mix, prod, abs, mul and mod on the shared 32x32 multiplier,
// SymCount+1 draws are needed, and each link probes slots until a free one.
// one item is worked on at a time; a new one is accepted once the result is
// in the output register, even while the receiver stalls it.
// reset clears the seeds and generator, start and previous symbols; the
// position memory holds nothing meaningful until the first rebuild.
// a stalled result holds its value until taken.
module chained_cycle_permutation_cipher import ccpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  symbol_i,
  input  logic        first_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  cipher_symbol_o,
  output logic        bad_symbol_o
);

  logic [31:0] type_seed_q, soft_seed_q;
  ccpc_cmd_t   cmd;
  ccpc_sts_t   sts;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? soft_seed_q : type_seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_seed_q <= '0;
      soft_seed_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) soft_seed_q <= pwdata;
      else          type_seed_q <= pwdata;
    end
  end

  ccpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .first_i    (first_of_string_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ccpc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .type_seed_i     (type_seed_q),
    .soft_seed_i     (soft_seed_q),
    .symbol_i        (symbol_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cipher_symbol_o (cipher_symbol_o),
    .bad_symbol_o    (bad_symbol_o)
  );

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_symbol_o |-> cipher_symbol_o == 8'd0)
    else $error("bad beat with nonzero code");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_symbol_o |->
      cipher_symbol_o >= 8'(FirstCode) && cipher_symbol_o < 8'(FirstCode + SymCount))
    else $error("code out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted a beat while still working");

endmodule
